// ===== hw/rtl/dpfl_pkg.sv =====
// Shared constants and types for the demand paging block.
package dpfl_pkg;
   localparam int PageWords  = 8;
   localparam int VirtPages  = 16;
   localparam int PhysFrames = 4;
   localparam int OffW  = $clog2(PageWords);
   localparam int PageW = $clog2(VirtPages);
   localparam int FrW   = $clog2(PhysFrames);
   localparam int RankW = $clog2(PhysFrames + 1);
   localparam int BsAw  = PageW + OffW;
   localparam int MsAw  = FrW + OffW;
   localparam int WordW = 32;
   localparam int AddrW = 8;
   localparam int VSpan = PageWords * VirtPages;
   localparam int PSpan = PageWords * PhysFrames;

   localparam logic [0:0] CSR_USE_LRU = 1'b0;

   typedef logic [WordW-1:0] word_type;
   typedef logic [RankW-1:0] rank_type;
endpackage

// ===== hw/rtl/dpfl_ram.sv =====
// Generic single-port RAM with registered read.
module dpfl_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// ===== hw/rtl/demand_paging_fifo_lru.sv =====
// Demand-paged memory with FIFO or LRU replacement, stores in single-port RAMs.
// A hit passes ACC, RDW and DONE before rsp_valid; an invalid address is answered
// from idle. A fault adds FAULT, a write-back (WBRD, WBWR) if the victim is dirty,
// then a load (LDRD, LDWR). One item at a time; an invalid address every cycle.
// Reset: a clearing pass writes all ones to both stores, busy high.
// Results cannot be stalled: each is shown for one cycle on rsp_valid.
module demand_paging_fifo_lru (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [7:0]  req_virt_addr,
   input  logic signed [31:0] req_write_data,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_read_data,
   output logic        rsp_status,
   output logic        rsp_page_fault,
   output logic        rsp_wrote_back,
   output logic [1:0]  rsp_frame,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int FW = dpfl_pkg::FrW;
   localparam int PW = dpfl_pkg::PageW;
   localparam int OW = dpfl_pkg::OffW;
   localparam int RW = dpfl_pkg::RankW;
   localparam int NF = dpfl_pkg::PhysFrames;
   localparam int NP = dpfl_pkg::VirtPages;
   localparam int AW8 = dpfl_pkg::AddrW;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_FAULT = 4'd2;
   localparam logic [3:0] ST_WBRD  = 4'd3;
   localparam logic [3:0] ST_WBWR  = 4'd4;
   localparam logic [3:0] ST_LDRD  = 4'd5;
   localparam logic [3:0] ST_LDWR  = 4'd6;
   localparam logic [3:0] ST_ACC   = 4'd7;
   localparam logic [3:0] ST_RDW   = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [dpfl_pkg::BsAw:0] cnt_ff, cnt_in;
   logic use_lru_ff;
   logic op_ff;
   logic [PW-1:0] page_ff;
   logic [OW-1:0] off_ff;
   dpfl_pkg::word_type wdata_ff;
   logic fault_ff, wb_ff;
   logic [FW-1:0] fr_ff, fr_in;
   logic [PW-1:0] victim_ff;
   logic [NP-1:0] valid_ff, dirty_ff;
   logic [FW-1:0] emap_ff [NP];
   dpfl_pkg::rank_type rank_ff [NF];
   logic [FW-1:0] fifo_ff;
   logic [FW:0] used_ff;

   logic bs_we, ms_we;
   logic [dpfl_pkg::BsAw-1:0] bs_addr;
   logic [dpfl_pkg::MsAw-1:0] ms_addr;
   dpfl_pkg::word_type bs_wd, ms_wd, bs_rd, ms_rd;

   logic rsp_valid_ff, rsp_status_ff, rsp_fault_ff, rsp_wb_ff;
   dpfl_pkg::word_type rsp_data_ff;
   logic [FW-1:0] rsp_frame_ff;

   logic accept;
   logic [OW-1:0] cnt_off;

   dpfl_ram #(.Width(dpfl_pkg::WordW), .Depth(dpfl_pkg::VSpan)) u_bs (
      .clock(clock), .we(bs_we), .addr(bs_addr), .wdata(bs_wd), .rdata(bs_rd));
   dpfl_ram #(.Width(dpfl_pkg::WordW), .Depth(dpfl_pkg::PSpan)) u_ms (
      .clock(clock), .we(ms_we), .addr(ms_addr), .wdata(ms_wd), .rdata(ms_rd));

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign cnt_off = cnt_ff[OW:1];

   // Victim choice: lowest rank, lowest index on ties
   logic [FW-1:0] lru_fr;
   always_comb begin
      lru_fr = '0;
      for (int i = 1; i < NF; i++) begin
         if (rank_ff[i] < rank_ff[lru_fr]) begin
            lru_fr = FW'(i);
         end
      end
   end

   // Page currently mapped to the victim frame
   logic [PW-1:0] map_pg;
   logic map_hit;
   always_comb begin
      map_pg  = '0;
      map_hit = 1'b0;
      for (int j = 0; j < NP; j++) begin
         if (valid_ff[j] && emap_ff[j] == fr_ff) begin
            map_pg  = PW'(j);
            map_hit = 1'b1;
         end
      end
   end

   always_comb begin
      bs_we = 1'b0; ms_we = 1'b0;
      bs_addr = '0; ms_addr = '0;
      bs_wd = ms_rd; ms_wd = bs_rd;
      state_in = state_ff;
      cnt_in = cnt_ff;
      fr_in = fr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            bs_we = 1'b1; ms_we = 1'b1;
            bs_wd = '1; ms_wd = '1;
            bs_addr = cnt_ff[dpfl_pkg::BsAw-1:0];
            ms_addr = cnt_ff[dpfl_pkg::MsAw-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (dpfl_pkg::BsAw+1)'(dpfl_pkg::VSpan - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_virt_addr >= AW8'(dpfl_pkg::VSpan)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_FAULT: begin
            cnt_in = '0;
            state_in = (map_hit && dirty_ff[map_pg]) ? ST_WBRD : ST_LDRD;
         end
         ST_WBRD: begin
            // read main word, next cycle write it out
            ms_addr = {fr_ff, cnt_off};
            cnt_in = cnt_ff + 1'b1;
            state_in = ST_WBWR;
         end
         ST_WBWR: begin
            bs_we = 1'b1;
            bs_addr = {victim_ff, cnt_off};
            if (cnt_off == OW'(dpfl_pkg::PageWords - 1)) begin
               cnt_in = '0;
               state_in = ST_LDRD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_WBRD;
            end
         end
         ST_LDRD: begin
            bs_addr = {page_ff, cnt_off};
            cnt_in = cnt_ff + 1'b1;
            state_in = ST_LDWR;
         end
         ST_LDWR: begin
            ms_we = 1'b1;
            ms_addr = {fr_ff, cnt_off};
            if (cnt_off == OW'(dpfl_pkg::PageWords - 1)) begin
               state_in = ST_ACC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_LDRD;
            end
         end
         ST_ACC: begin
            ms_addr = {fr_ff, off_ff};
            ms_wd = wdata_ff;
            if (!valid_ff[page_ff]) begin
               state_in = ST_FAULT;
               if (used_ff < (FW+1)'(NF)) begin
                  fr_in = used_ff[FW-1:0];
               end else if (use_lru_ff) begin
                  fr_in = lru_fr;
               end else begin
                  fr_in = fifo_ff;
               end
            end else begin
               fr_in = emap_ff[page_ff];
               ms_addr = {fr_in, off_ff};
               ms_we = op_ff;
               state_in = ST_RDW;
            end
         end
         ST_RDW: begin
            // hold the read address so ms_rd stays valid into DONE
            ms_addr = {fr_ff, off_ff};
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         use_lru_ff   <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         fifo_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NF; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fr_ff        <= fr_in;
         rsp_valid_ff <= 1'b0;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == dpfl_pkg::CSR_USE_LRU) begin
            use_lru_ff <= csr_pwdata[0];
         end
         if (state_ff == ST_IDLE && accept) begin
            op_ff    <= req_op;
            page_ff  <= req_virt_addr[OW+PW-1:OW];
            off_ff   <= req_virt_addr[OW-1:0];
            wdata_ff <= req_write_data;
            fault_ff <= 1'b0;
            wb_ff    <= 1'b0;
            if (req_virt_addr >= AW8'(dpfl_pkg::VSpan)) begin
               // invalid address: answer at once, touch no store or page table
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= 1'b1;
               rsp_data_ff   <= '0;
               rsp_fault_ff  <= 1'b0;
               rsp_wb_ff     <= 1'b0;
               rsp_frame_ff  <= '0;
            end
         end
         if (state_ff == ST_ACC && !valid_ff[page_ff]) begin
            fault_ff <= 1'b1;
            if (used_ff < (FW+1)'(NF)) begin
               used_ff <= used_ff + 1'b1;
               if (use_lru_ff) begin
                  for (int i = 0; i < NF; i++) begin
                     if (rank_ff[i] > RW'(1)) rank_ff[i] <= rank_ff[i] - 1'b1;
                  end
                  rank_ff[used_ff[FW-1:0]] <= RW'(used_ff) + 1'b1;
               end else begin
                  rank_ff[used_ff[FW-1:0]] <= RW'(1);
               end
            end else if (use_lru_ff) begin
               for (int i = 0; i < NF; i++) begin
                  if (rank_ff[i] > rank_ff[lru_fr]) rank_ff[i] <= rank_ff[i] - 1'b1;
               end
               rank_ff[lru_fr] <= RW'(NF);
            end else begin
               fifo_ff <= fifo_ff + 1'b1;
            end
         end
         if (state_ff == ST_FAULT) begin
            victim_ff <= map_pg;
            if (map_hit) begin
               wb_ff <= dirty_ff[map_pg];
               valid_ff[map_pg] <= 1'b0;
               dirty_ff[map_pg] <= 1'b0;
            end
            valid_ff[page_ff] <= 1'b1;
            dirty_ff[page_ff] <= 1'b0;
            emap_ff[page_ff]  <= fr_ff;
         end
         if (state_ff == ST_ACC && valid_ff[page_ff]) begin
            if (op_ff) dirty_ff[page_ff] <= 1'b1;
            if (use_lru_ff) begin
               for (int i = 0; i < NF; i++) begin
                  if (rank_ff[i] > rank_ff[fr_in]) rank_ff[i] <= rank_ff[i] - 1'b1;
               end
               rank_ff[fr_in] <= RW'(NF);
            end
         end
         if (state_ff == ST_DONE) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= 1'b0;
            rsp_data_ff   <= op_ff ? '0 : ms_rd;
            rsp_fault_ff  <= fault_ff;
            rsp_wb_ff     <= wb_ff;
            rsp_frame_ff  <= fr_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_page_fault = rsp_fault_ff;
   assign rsp_wrote_back = rsp_wb_ff;
   assign rsp_frame      = 2'(rsp_frame_ff);
   assign csr_prdata     = {31'd0, use_lru_ff};
   assign csr_pready     = 1'b1;
endmodule
